/* hw/rtl/abtt_pkg.sv */
`default_nettype none

package abtt_pkg;

  localparam int MAX_TOKEN = 64;

  localparam logic [7:0] CHAR_OPEN  = 8'h3c;
  localparam logic [7:0] CHAR_CLOSE = 8'h3e;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_Z  = 8'h7a;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  typedef enum logic [1:0] {
    DELIM_NONE  = 2'd0,
    DELIM_OPEN  = 2'd1,
    DELIM_CLOSE = 2'd2
  } delim_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNMATCHED = 2'd1,
    STATUS_TRUNCATED = 2'd2
  } status_t;

  function automatic delim_t classify(input logic [7:0] b);
    delim_t d;
    d = DELIM_NONE;
    if (b == CHAR_OPEN) begin
      d = DELIM_OPEN;
    end else if (b == CHAR_CLOSE) begin
      d = DELIM_CLOSE;
    end
    return d;
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= CHAR_LC_A && b <= CHAR_LC_Z) begin
      r = b & ~CASE_BIT;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/abtt_in_if.sv */
`default_nettype none

interface abtt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

/* hw/rtl/abtt_out_if.sv */
`default_nettype none

interface abtt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] token_byte;
  logic       in_tag;
  logic       token_last;
  logic [1:0] status;

  modport source (output valid, output token_byte, output in_tag, output token_last,
                  output status, input ready);
  modport sink   (input valid, input token_byte, input in_tag, input token_last,
                  input status, output ready);
endinterface

`default_nettype wire

/* hw/rtl/angle_bracket_tag_tokenizer.sv */
`default_nettype none

// Tokenizer for markup text, split at '<' and '>'.
// in_ch carries one text byte per word, or an end-of-text marker. out_ch
// carries one word per emitted token byte (uppercased for tags), with
// token_last on the final byte, or a single error word for an unmatched
// bracket, after which input is swallowed until end of text.
// Bytes of the pending token are kept in a MAX_TOKEN-deep buffer memory
// with a registered read port. A byte that ends no token is stored in the
// buffer while it has room. Once a word that ends a token is taken, the
// token is replayed out of the buffer one byte per cycle while the
// receiver does not stall; in_ch is held off during replay and while an
// error word is sent. Each token byte passes from the buffer read register
// into the output register, which drives out_ch: when the receiver stalls,
// replay pauses and the buffer read address holds. A pending result in
// that register does not block the input from being taken.
// Synchronous reset clears all scan state and drops any output word; the
// buffer contents are left as they are and are never read before written.
module angle_bracket_tag_tokenizer #(
  parameter int MAX_TOKEN = abtt_pkg::MAX_TOKEN
) (
  input  wire         clk,
  input  wire         rst_n,
  abtt_in_if.sink     in_ch,
  abtt_out_if.source  out_ch
);

  localparam int IdxW = (MAX_TOKEN > 1) ? $clog2(MAX_TOKEN) : 1;
  localparam int LenW = $clog2(MAX_TOKEN + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_ERR
  } state_t;

  state_t              state_r, state_nxt;
  logic [LenW-1:0]     len_r, len_nxt;
  logic                obb_r, obb_nxt;
  abtt_pkg::delim_t    first_r, first_nxt;
  abtt_pkg::delim_t    last_r, last_nxt;
  logic                trunc_r, trunc_nxt;
  logic                halted_r, halted_nxt;

  logic [LenW-1:0]     emit_len_r, emit_len_nxt;
  logic                emit_tag_r, emit_tag_nxt;
  logic                emit_trunc_r, emit_trunc_nxt;
  logic [IdxW-1:0]     idx_r, idx_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_byte_r, out_byte_nxt;
  logic                out_tag_r, out_tag_nxt;
  logic                out_last_r, out_last_nxt;
  abtt_pkg::status_t   out_status_r, out_status_nxt;

  logic [7:0]          token_mem [MAX_TOKEN];
  logic [7:0]          mem_q_r;
  logic [IdxW-1:0]     rd_addr;
  logic                mem_we;

  logic                accept;
  logic                out_free;
  logic                emit_last;
  abtt_pkg::delim_t    delim;
  logic [7:0]          emit_byte;

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign accept            = in_ch.valid && (state_r == ST_IDLE);
  assign out_free          = !out_valid_r || out_ch.ready;
  assign delim             = abtt_pkg::classify(in_ch.text_byte);
  assign emit_last         = ((LenW'(idx_r) + LenW'(1)) == emit_len_r);
  assign emit_byte         = emit_tag_r ? abtt_pkg::to_upper(mem_q_r) : mem_q_r;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.token_byte = out_byte_r;
  assign out_ch.in_tag     = out_tag_r;
  assign out_ch.token_last = out_last_r;
  assign out_ch.status     = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    obb_nxt        = obb_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    trunc_nxt      = trunc_r;
    halted_nxt     = halted_r;
    emit_len_nxt   = emit_len_r;
    emit_tag_nxt   = emit_tag_r;
    emit_trunc_nxt = emit_trunc_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_byte_nxt   = out_byte_r;
    out_tag_nxt    = out_tag_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    rd_addr        = idx_r;
    mem_we         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.end_of_text) begin
            if (!halted_r && len_r != '0) begin
              emit_len_nxt   = len_r;
              emit_tag_nxt   = 1'b0;
              emit_trunc_nxt = trunc_r;
              idx_nxt        = '0;
              rd_addr        = '0;
              state_nxt      = ST_EMIT;
            end
            len_nxt    = '0;
            obb_nxt    = 1'b0;
            trunc_nxt  = 1'b0;
            first_nxt  = abtt_pkg::DELIM_NONE;
            last_nxt   = abtt_pkg::DELIM_NONE;
            halted_nxt = 1'b0;
          end else if (!halted_r) begin
            if (delim != abtt_pkg::DELIM_NONE) begin
              if (len_r == '0) begin
                last_nxt = delim;
              end else if (obb_r != (delim == abtt_pkg::DELIM_CLOSE)) begin
                len_nxt    = '0;
                obb_nxt    = 1'b0;
                trunc_nxt  = 1'b0;
                halted_nxt = 1'b1;
                state_nxt  = ST_ERR;
              end else begin
                emit_len_nxt   = len_r;
                emit_tag_nxt   = obb_r;
                emit_trunc_nxt = trunc_r;
                idx_nxt        = '0;
                rd_addr        = '0;
                state_nxt      = ST_EMIT;
                first_nxt      = delim;
                last_nxt       = delim;
                len_nxt        = '0;
                obb_nxt        = 1'b0;
                trunc_nxt      = 1'b0;
              end
            end else begin
              // first byte of a token decides whether it opened with a bracket
              if (len_r == '0) begin
                obb_nxt = (first_r == abtt_pkg::DELIM_OPEN) ||
                          (last_r == abtt_pkg::DELIM_OPEN);
              end
              if (len_r < LenW'(MAX_TOKEN)) begin
                mem_we  = 1'b1;
                len_nxt = len_r + LenW'(1);
              end else begin
                trunc_nxt = 1'b1;
              end
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = emit_byte;
          out_tag_nxt    = emit_tag_r;
          out_last_nxt   = emit_last;
          out_status_nxt = emit_trunc_r ? abtt_pkg::STATUS_TRUNCATED
                                        : abtt_pkg::STATUS_OK;
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + IdxW'(1);
            rd_addr = idx_r + IdxW'(1);
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = '0;
          out_tag_nxt    = 1'b0;
          out_last_nxt   = 1'b1;
          out_status_nxt = abtt_pkg::STATUS_UNMATCHED;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // token buffer: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      token_mem[len_r[IdxW-1:0]] <= in_ch.text_byte;
    end
    mem_q_r <= token_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      obb_r       <= 1'b0;
      first_r     <= abtt_pkg::DELIM_NONE;
      last_r      <= abtt_pkg::DELIM_NONE;
      trunc_r     <= 1'b0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      obb_r       <= obb_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      trunc_r     <= trunc_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
    emit_len_r   <= emit_len_nxt;
    emit_tag_r   <= emit_tag_nxt;
    emit_trunc_r <= emit_trunc_nxt;
    idx_r        <= idx_nxt;
    out_byte_r   <= out_byte_nxt;
    out_tag_r    <= out_tag_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

`default_nettype wire

/* tb/sv/tokenizer_checker.sv */
`timescale 1ns / 1ps

module tokenizer_checker (
  input  wire  clk,
  input  wire  rst_n,
  abtt_in_if   in_ch,
  abtt_out_if  out_ch,
  output int   mismatches,
  output int   words_due
);

  typedef struct packed {
    logic [7:0]        token_byte;
    logic              in_tag;
    logic              token_last;
    abtt_pkg::status_t status;
  } result_word_t;

  localparam int IdxW = (abtt_pkg::MAX_TOKEN > 1) ? $clog2(abtt_pkg::MAX_TOKEN) : 1;

  result_word_t       due_q[$];
  logic [7:0]         held_bytes [abtt_pkg::MAX_TOKEN];
  logic [6:0]         held_count;
  logic               opened;
  logic               dropped;
  logic               halted;
  abtt_pkg::delim_t   ended_by;
  abtt_pkg::delim_t   last_seen;
  int                 fail_count;

  task automatic forget_token();
    held_count = '0;
    opened     = 1'b0;
    dropped    = 1'b0;
  endtask

  task automatic release_token(input logic tag);
    result_word_t w;
    for (int i = 0; i < held_count; i++) begin
      w.token_byte = held_bytes[i];
      if (tag && w.token_byte >= abtt_pkg::CHAR_LC_A &&
          w.token_byte <= abtt_pkg::CHAR_LC_Z) begin
        w.token_byte = w.token_byte - abtt_pkg::CASE_BIT;
      end
      w.in_tag     = tag;
      w.token_last = (i + 1 == held_count);
      w.status     = dropped ? abtt_pkg::STATUS_TRUNCATED : abtt_pkg::STATUS_OK;
      due_q.push_back(w);
    end
  endtask

  task automatic predict_word(input logic [7:0] b, input logic eot);
    abtt_pkg::delim_t d;
    result_word_t     w;
    if (eot) begin
      // a token cut off by the end of text always comes out as plain text
      if (!halted && held_count != 0) begin
        release_token(1'b0);
      end
      forget_token();
      ended_by  = abtt_pkg::DELIM_NONE;
      last_seen = abtt_pkg::DELIM_NONE;
      halted    = 1'b0;
    end else if (!halted) begin
      d = abtt_pkg::DELIM_NONE;
      if (b == abtt_pkg::CHAR_OPEN) begin
        d = abtt_pkg::DELIM_OPEN;
      end else if (b == abtt_pkg::CHAR_CLOSE) begin
        d = abtt_pkg::DELIM_CLOSE;
      end
      if (d != abtt_pkg::DELIM_NONE) begin
        if (held_count == 0) begin
          last_seen = d;
        end else if (opened != (d == abtt_pkg::DELIM_CLOSE)) begin
          w.token_byte = 8'h00;
          w.in_tag     = 1'b0;
          w.token_last = 1'b1;
          w.status     = abtt_pkg::STATUS_UNMATCHED;
          due_q.push_back(w);
          forget_token();
          halted = 1'b1;
        end else begin
          release_token(opened);
          ended_by  = d;
          last_seen = d;
          forget_token();
        end
      end else begin
        if (held_count == 0) begin
          opened = (ended_by == abtt_pkg::DELIM_OPEN || last_seen == abtt_pkg::DELIM_OPEN);
        end
        if (held_count < abtt_pkg::MAX_TOKEN) begin
          held_bytes[held_count[IdxW-1:0]] = b;
          held_count = held_count + 1'b1;
        end else begin
          dropped = 1'b1;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    result_word_t w;
    if (!rst_n) begin
      due_q.delete();
      forget_token();
      ended_by   = abtt_pkg::DELIM_NONE;
      last_seen  = abtt_pkg::DELIM_NONE;
      halted     = 1'b0;
      fail_count = 0;
    end else begin
      // a result never shows up on the edge that takes the word causing it
      if (in_ch.valid && in_ch.ready) begin
        predict_word(in_ch.text_byte, in_ch.end_of_text);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (due_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected word byte=%h tag=%b last=%b status=%0d", $time,
                   out_ch.token_byte, out_ch.in_tag, out_ch.token_last, out_ch.status);
        end else begin
          w = due_q.pop_front();
          if (out_ch.token_byte !== w.token_byte || out_ch.in_tag !== w.in_tag ||
              out_ch.token_last !== w.token_last || out_ch.status !== w.status) begin
            fail_count++;
            $display("%0t: expected byte=%h tag=%b last=%b status=%0d, got byte=%h tag=%b last=%b status=%0d",
                     $time, w.token_byte, w.in_tag, w.token_last, w.status,
                     out_ch.token_byte, out_ch.in_tag, out_ch.token_last, out_ch.status);
          end
        end
      end
    end
    mismatches <= fail_count;
    words_due  <= due_q.size();
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int IDLE_LIMIT    = 5000;
  localparam int SETTLE_CYCLES = 2 * abtt_pkg::MAX_TOKEN + 8;
  localparam int RANDOM_WORDS  = 320;

  logic clk = 1'b0;
  logic rst_n;
  logic calm;
  int   stall_left;
  int   idle_cycles = 0;
  int   words_sent;
  int   mismatches;
  int   words_due;

  abtt_in_if  in_ch ();
  abtt_out_if out_ch ();

  angle_bracket_tag_tokenizer u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tokenizer_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .words_due  (words_due)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
  endfunction

  // text byte that is never a delimiter, weighted toward letters
  function automatic logic [7:0] pick_char();
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0, 1: b = abtt_pkg::CHAR_LC_A + 8'($urandom_range(0, 25));
      2: b = abtt_pkg::CHAR_LC_A - abtt_pkg::CASE_BIT + 8'($urandom_range(0, 25));
      default: b = 8'($urandom_range(0, 255));
    endcase
    if (b == abtt_pkg::CHAR_OPEN || b == abtt_pkg::CHAR_CLOSE) begin
      b = b ^ 8'h01;
    end
    return b;
  endfunction

  function automatic logic [7:0] pick_delim();
    return $urandom_range(0, 1) ? abtt_pkg::CHAR_OPEN : abtt_pkg::CHAR_CLOSE;
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic put_word(input logic [7:0] b, input logic eot);
    in_ch.valid       <= 1'b1;
    in_ch.text_byte   <= b;
    in_ch.end_of_text <= eot;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    if (!calm && $urandom_range(0, 2) == 0) begin
      in_ch.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  task automatic put_string(input string s);
    for (int i = 0; i < s.len(); i++) begin
      put_word(s[i], 1'b0);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
  endtask

  // mostly well-formed markup: tags and plain text alternate, with the odd
  // wrong closing bracket and the odd token left open at end of text
  task automatic send_markup(input int first_len);
    int         tokens;
    int         len;
    logic       tag;
    logic       bad;
    logic [7:0] last_delim;
    logic [7:0] closing;
    tokens = $urandom_range(1, 6);
    tag    = 1'($urandom_range(0, 1));
    if (tag) begin
      repeat ($urandom_range(0, 2)) put_word(pick_delim(), 1'b0);
      put_word(abtt_pkg::CHAR_OPEN, 1'b0);
    end else if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(0, 2)) put_word(pick_delim(), 1'b0);
      put_word(abtt_pkg::CHAR_CLOSE, 1'b0);
    end
    for (int t = 0; t < tokens; t++) begin
      if (t == 0 && first_len > 0) begin
        len = first_len;
      end else if ($urandom_range(0, 15) == 0) begin
        len = $urandom_range(9, 30);
      end else begin
        len = $urandom_range(1, 8);
      end
      repeat (len) put_word(pick_char(), 1'b0);
      if (t == tokens - 1 && $urandom_range(0, 2) == 0) begin
        break;
      end
      bad     = ($urandom_range(0, 9) == 0);
      closing = (tag ^ bad) ? abtt_pkg::CHAR_CLOSE : abtt_pkg::CHAR_OPEN;
      put_word(closing, 1'b0);
      last_delim = closing;
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) begin
          last_delim = pick_delim();
          put_word(last_delim, 1'b0);
        end
      end
      tag = (closing == abtt_pkg::CHAR_OPEN) || (last_delim == abtt_pkg::CHAR_OPEN);
    end
    put_word(8'h00, 1'b1);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 12)) begin
      if ($urandom_range(0, 2) == 0) begin
        put_word(pick_delim(), 1'b0);
      end else begin
        put_word(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      end
    end
    put_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.text_byte   <= 8'h00;
    in_ch.end_of_text <= 1'b0;
    rst_n             <= 1'b0;
    calm       = 1'b0;
    words_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // empty text, then a text of delimiters only
    put_word(8'hff, 1'b1);
    put_string(">>");
    put_word(8'h00, 1'b1);
    // tag with case boundaries, then plain text closed by an open bracket
    put_string("<az`{A>q<");
    put_word(8'h00, 1'b1);
    // zero and all-ones bytes flushed by end of text
    put_word(8'h00, 1'b0);
    put_word(8'hff, 1'b0);
    put_word(8'h00, 1'b1);
    // plain token closed by '>' halts the text; the rest is swallowed
    put_string("x>y<");
    put_word(8'h00, 1'b1);
    // tag closed by '<'
    put_string("<m<");
    put_word(8'h00, 1'b1);
    drain();

    words_sent = 0;
    // full-size token, then one that overflows the buffer
    send_markup(abtt_pkg::MAX_TOKEN);
    send_markup($urandom_range(abtt_pkg::MAX_TOKEN + 1, abtt_pkg::MAX_TOKEN + 6));
    while (words_sent < RANDOM_WORDS) begin
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 4) == 0) begin
        send_noise();
      end else begin
        send_markup(0);
      end
      if ($urandom_range(0, 5) == 0) begin
        drain();
      end
    end
    calm = 1'b0;

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && words_due == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
